// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked and gated by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tbhd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbhd_pkg
// Types and constants for the touch baseline hysteresis detector.
// ----------------------------------------------------------------------------
package tbhd_pkg;

    localparam int CH_W      = 3;
    localparam int VAL_W     = 16;
    localparam int BASE_W    = 15;
    localparam int DELTA_W   = 16;
    localparam int ACT_W     = 2;
    localparam int HYST_W    = 15;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam logic [BASE_W-1:0] MAX15 = 15'h7FFF;

    localparam logic [HYST_W-1:0]  HYST_RST  = 15'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd4;
    localparam logic [BASE_W-1:0]  LIMIT_RST = 15'd32767;

    localparam logic [CFG_IDX_W-1:0] CFG_HYST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    typedef enum logic [ACT_W-1:0] {
        ACT_SCAN    = 2'd0,
        ACT_CAL     = 2'd1,
        ACT_SET_THR = 2'd2
    } t_action;

    typedef struct packed {
        logic              touched;
        logic [BASE_W-1:0] thr;
        logic [BASE_W-1:0] base;
    } t_entry;

endpackage

// ===== rtl/touch_baseline_hysteresis_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_baseline_hysteresis_detector
// Per-channel capacitive touch detector with baseline tracking and hysteresis.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and gives one result
// per item: the per-channel state memory is read synchronously when the item is
// accepted, and the update stage writes the entry back and loads the output
// register. Back-to-back items on the same channel see the updated entry
// through a forwarding register. Entries read as their reset values (baseline
// zero, not touched, threshold DEFAULT_THRESHOLD) until first written, tracked
// by one valid flop per channel, so no clearing pass is needed after reset.
// Channel numbers at or above CHANNELS return zeros and change nothing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_baseline_hysteresis_detector #(
    parameter int CHANNELS          = 8,
    parameter int DEFAULT_THRESHOLD = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // channel[2:0], value[18:3], zero pad
    input  logic [1:0]  i_s_tuser,   // action[1:0]
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // channel_out[2:0], delta[18:3], touched[19],
                                     // baseline_out[34:20], zero pad
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    localparam int LP_MAXCH = 2 ** tbhd_pkg::CH_W;
    localparam int LP_DEPTH = (CHANNELS < LP_MAXCH) ? CHANNELS : LP_MAXCH;
    localparam int LP_AW    = (LP_DEPTH > 1) ? $clog2(LP_DEPTH) : 1;

    localparam tbhd_pkg::t_entry LP_RST_ENTRY = '{
        touched: 1'b0,
        thr:     tbhd_pkg::BASE_W'(DEFAULT_THRESHOLD),
        base:    '0
    };

    // configuration registers
    logic [tbhd_pkg::HYST_W-1:0]  r_hyst;
    logic [tbhd_pkg::SHIFT_W-1:0] r_shift;
    logic [tbhd_pkg::BASE_W-1:0]  r_limit;

    // state memory
    tbhd_pkg::t_entry r_mem [LP_DEPTH];
    logic [LP_DEPTH-1:0] r_vld;
    tbhd_pkg::t_entry r_rd;
    logic             r_rd_vld;
    logic             r_fwd;
    tbhd_pkg::t_entry r_fwd_data;

    // input decode
    logic [tbhd_pkg::CH_W-1:0]   w_in_chan;
    logic [tbhd_pkg::VAL_W-1:0]  w_in_val;
    logic [LP_AW-1:0]            w_in_idx;
    logic                        w_in_rng;
    logic [tbhd_pkg::BASE_W-1:0] w_in_sample;
    logic                        w_acc;

    // update stage
    logic                        r_s1_vld;
    logic [tbhd_pkg::ACT_W-1:0]  r_s1_act;
    logic [tbhd_pkg::CH_W-1:0]   r_s1_chan;
    logic [LP_AW-1:0]            r_s1_idx;
    logic                        r_s1_rng;
    logic [tbhd_pkg::BASE_W-1:0] r_s1_sample;
    logic [tbhd_pkg::VAL_W-1:0]  r_s1_value;
    logic                        w_s1_adv;
    logic                        w_wr_en;

    tbhd_pkg::t_entry   w_cur;
    tbhd_pkg::t_entry   w_wr_entry;
    logic signed [16:0] w_delta;
    logic signed [16:0] w_thr;
    logic signed [16:0] w_rel;
    logic signed [16:0] w_corr;
    logic signed [17:0] w_nb;
    logic               w_scan_t;
    logic [tbhd_pkg::BASE_W-1:0] w_scan_base;
    logic [tbhd_pkg::BASE_W-1:0] w_thr_sat;
    logic [tbhd_pkg::DELTA_W-1:0] w_res_delta;
    logic               w_res_touched;
    logic [tbhd_pkg::BASE_W-1:0] w_res_base;

    // output register
    logic                         r_out_vld;
    logic [tbhd_pkg::CH_W-1:0]    r_out_chan;
    logic [tbhd_pkg::DELTA_W-1:0] r_out_delta;
    logic                         r_out_touched;
    logic [tbhd_pkg::BASE_W-1:0]  r_out_base;

    assign w_in_chan = i_s_tdata[tbhd_pkg::CH_W-1:0];
    assign w_in_val  = i_s_tdata[tbhd_pkg::CH_W +: tbhd_pkg::VAL_W];
    assign w_in_idx  = w_in_chan[LP_AW-1:0];
    assign w_in_rng  = ({{(32-tbhd_pkg::CH_W){1'b0}}, w_in_chan} < 32'(CHANNELS));
    assign w_in_sample = (w_in_val < {1'b0, r_limit}) ? w_in_val[tbhd_pkg::BASE_W-1:0]
                                                       : r_limit;

    assign w_s1_adv   = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || w_s1_adv;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_wr_en    = r_s1_vld && w_s1_adv && r_s1_rng;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst  <= tbhd_pkg::HYST_RST;
            r_shift <= tbhd_pkg::SHIFT_RST;
            r_limit <= tbhd_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tbhd_pkg::CFG_HYST:  r_hyst  <= i_cfg_data;
                tbhd_pkg::CFG_SHIFT: r_shift <= i_cfg_data[tbhd_pkg::SHIFT_W-1:0];
                tbhd_pkg::CFG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state memory: read at accept, write back from the update stage
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_s1_idx] <= w_wr_entry;
        end
        if (w_acc) begin
            r_rd <= r_mem[w_in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fwd_data  <= w_wr_entry;
            r_s1_act    <= i_s_tuser;
            r_s1_chan   <= w_in_chan;
            r_s1_idx    <= w_in_idx;
            r_s1_rng    <= w_in_rng;
            r_s1_sample <= w_in_sample;
            r_s1_value  <= w_in_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_vld[r_s1_idx] <= 1'b1;
            end
            if (w_acc) begin
                r_rd_vld <= r_vld[w_in_idx];
                r_fwd    <= w_wr_en && (w_in_idx == r_s1_idx);
                r_s1_vld <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_vld <= 1'b0;
                r_fwd    <= 1'b0;
            end
        end
    end

    // update stage
    assign w_cur = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd : LP_RST_ENTRY);

    assign w_delta = signed'({2'b00, r_s1_sample}) - signed'({2'b00, w_cur.base});
    assign w_thr   = signed'({2'b00, w_cur.thr});
    assign w_rel   = w_thr - signed'({2'b00, r_hyst});
    assign w_corr  = w_delta >>> r_shift;
    assign w_nb    = signed'({3'b000, w_cur.base}) + {w_corr[16], w_corr};
    assign w_thr_sat = (r_s1_value < {1'b0, tbhd_pkg::MAX15})
                     ? r_s1_value[tbhd_pkg::BASE_W-1:0] : tbhd_pkg::MAX15;

    always_comb begin
        if (!w_cur.touched) begin
            w_scan_t = (w_delta > w_thr);
        end else begin
            w_scan_t = !(w_delta < w_rel);
        end
        if (!w_scan_t) begin
            if (w_nb < 0) begin
                w_scan_base = '0;
            end else if (w_nb > signed'({3'b000, tbhd_pkg::MAX15})) begin
                w_scan_base = tbhd_pkg::MAX15;
            end else begin
                w_scan_base = w_nb[tbhd_pkg::BASE_W-1:0];
            end
        end else if ((w_cur.base != '0) && (w_delta < 0)) begin
            w_scan_base = w_cur.base - 1'b1;
        end else begin
            w_scan_base = w_cur.base;
        end
    end

    always_comb begin
        w_wr_entry  = w_cur;
        w_res_delta = '0;
        case (tbhd_pkg::t_action'(r_s1_act))
            tbhd_pkg::ACT_SCAN: begin
                w_wr_entry.touched = w_scan_t;
                w_wr_entry.base    = w_scan_base;
                w_res_delta        = w_delta[tbhd_pkg::DELTA_W-1:0];
            end
            tbhd_pkg::ACT_CAL: begin
                w_wr_entry.touched = 1'b0;
                w_wr_entry.base    = r_s1_sample;
            end
            tbhd_pkg::ACT_SET_THR: begin
                w_wr_entry.thr = w_thr_sat;
            end
            default: ;
        endcase
        if (r_s1_rng) begin
            w_res_touched = w_wr_entry.touched;
            w_res_base    = w_wr_entry.base;
        end else begin
            w_res_delta   = '0;
            w_res_touched = 1'b0;
            w_res_base    = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_s1_vld && w_s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld && w_s1_adv) begin
            r_out_chan    <= r_s1_chan;
            r_out_delta   <= w_res_delta;
            r_out_touched <= w_res_touched;
            r_out_base    <= w_res_base;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b00000, r_out_base, r_out_touched, r_out_delta, r_out_chan};

    `ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n,
        r_s1_vld && r_out_vld && !i_m_tready, !o_s_tready)
    `ASSERT_IMP(a_fwd_needs_stage, i_clk, i_rst_n, r_fwd, r_s1_vld)
    `ASSERT_IMP(a_out_of_range_zero, i_clk, i_rst_n,
        r_out_vld && (32'(r_out_chan) >= 32'(CHANNELS)),
        (r_out_delta == '0) && !r_out_touched && (r_out_base == '0))
    `ASSERT_NXT(a_cal_clears_touch, i_clk, i_rst_n,
        r_s1_vld && w_s1_adv && (r_s1_act == tbhd_pkg::ACT_CAL), !r_out_touched)

endmodule

// ===== verif/touch_baseline_hysteresis_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_baseline_hysteresis_detector_tb
// Self-checking bench for the per-channel touch detector. A tracker class keeps
// its own copy of every channel's baseline, touch flag and threshold, works out
// the report due for each accepted item and compares each received report with
// the oldest one due. Directed items hit the clamp, saturation and hysteresis
// corners; random phases sweep the registers and the stream stall patterns.
// ----------------------------------------------------------------------------
module touch_baseline_hysteresis_detector_tb;

    localparam int N_CH        = 8;
    localparam int DEFAULT_THR = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;

    // unused action code: changes nothing
    localparam logic [tbhd_pkg::ACT_W-1:0] ACT_NONE = 2'd3;

    // report as packed on o_m_tdata, lowest field last
    typedef struct packed {
        logic [4:0]                   pad;
        logic [tbhd_pkg::BASE_W-1:0]  base;
        logic                         touched;
        logic [tbhd_pkg::DELTA_W-1:0] delta;
        logic [tbhd_pkg::CH_W-1:0]    ch;
    } t_report;

    class touch_tracker;
        logic [tbhd_pkg::BASE_W-1:0]  base  [N_CH];
        logic                         touch [N_CH];
        logic [tbhd_pkg::BASE_W-1:0]  thr   [N_CH];
        logic [tbhd_pkg::HYST_W-1:0]  hyst;
        logic [tbhd_pkg::SHIFT_W-1:0] shift;
        logic [tbhd_pkg::BASE_W-1:0]  limit;
        t_report                      due_reports [$];
        int                           errors;

        function new();
            hyst   = tbhd_pkg::HYST_RST;
            shift  = tbhd_pkg::SHIFT_RST;
            limit  = tbhd_pkg::LIMIT_RST;
            errors = 0;
            foreach (base[i]) begin
                base[i]  = '0;
                touch[i] = 1'b0;
                thr[i]   = tbhd_pkg::BASE_W'(DEFAULT_THR);
            end
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%0t: mismatch: %s", $time, msg);
            end
        endfunction

        function void note_item(logic [tbhd_pkg::ACT_W-1:0] act,
                                logic [tbhd_pkg::CH_W-1:0] ch,
                                logic [tbhd_pkg::VAL_W-1:0] value);
            t_report r;
            int      sample;
            int      dlt;
            int      lvl;
            int      nb;
            sample = (int'(value) < int'(limit)) ? int'(value) : int'(limit);
            dlt    = 0;
            case (act)
                tbhd_pkg::ACT_SCAN: begin
                    lvl = int'(thr[ch]);
                    dlt = sample - int'(base[ch]);
                    if (!touch[ch] && dlt > lvl) begin
                        touch[ch] = 1'b1;
                    end else if (touch[ch] && dlt < lvl - int'(hyst)) begin
                        touch[ch] = 1'b0;
                    end
                    if (!touch[ch]) begin
                        nb = int'(base[ch]) + (dlt >>> shift);
                        if (nb < 0) nb = 0;
                        if (nb > int'(tbhd_pkg::MAX15)) nb = int'(tbhd_pkg::MAX15);
                        base[ch] = nb[tbhd_pkg::BASE_W-1:0];
                    end else if (base[ch] != '0 && dlt < 0) begin
                        base[ch] = base[ch] - 1'b1;
                    end
                end
                tbhd_pkg::ACT_CAL: begin
                    base[ch]  = sample[tbhd_pkg::BASE_W-1:0];
                    touch[ch] = 1'b0;
                end
                tbhd_pkg::ACT_SET_THR: begin
                    thr[ch] = (value < tbhd_pkg::VAL_W'(tbhd_pkg::MAX15))
                            ? value[tbhd_pkg::BASE_W-1:0] : tbhd_pkg::MAX15;
                end
                default: ;
            endcase
            r.pad     = '0;
            r.base    = base[ch];
            r.touched = touch[ch];
            r.delta   = dlt[tbhd_pkg::DELTA_W-1:0];
            r.ch      = ch;
            due_reports.push_back(r);
        endfunction

        function void check_report(logic [39:0] data);
            t_report got;
            t_report want;
            got = data;
            if (due_reports.size() == 0) begin
                flag($sformatf("result with none due: %h", data));
                return;
            end
            want = due_reports.pop_front();
            if (got.ch !== want.ch || got.delta !== want.delta ||
                got.touched !== want.touched || got.base !== want.base ||
                got.pad !== want.pad) begin
                flag($sformatf({"exp/got ch %0d/%0d delta %0d/%0d touched %b/%b ",
                                "baseline %0d/%0d pad %h/%h"},
                               want.ch, got.ch, $signed(want.delta), $signed(got.delta),
                               want.touched, got.touched, want.base, got.base,
                               want.pad, got.pad));
            end
        endfunction
    endclass

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata  = '0;
    logic [tbhd_pkg::ACT_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [39:0]                    m_tdata;
    logic                           cfg_we   = 1'b0;
    logic [tbhd_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [tbhd_pkg::CFG_W-1:0]     cfg_data = '0;

    touch_tracker tracker;
    int           src_idle_pct = 0;
    int           snk_stall_pct = 0;
    int           cycles = 0;

    touch_baseline_hysteresis_detector #(
        .CHANNELS          (N_CH),
        .DEFAULT_THRESHOLD (DEFAULT_THR)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            tracker.check_report(m_tdata);
        end
    end

    // entered and left at a falling edge
    task automatic push_item(logic [tbhd_pkg::ACT_W-1:0] act,
                             logic [tbhd_pkg::CH_W-1:0] ch,
                             logic [tbhd_pkg::VAL_W-1:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, ch};
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.note_item(act, ch, value);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.due_reports.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_config(logic [tbhd_pkg::HYST_W-1:0] h,
                                logic [tbhd_pkg::SHIFT_W-1:0] s,
                                logic [tbhd_pkg::BASE_W-1:0] l);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= tbhd_pkg::CFG_HYST;
        cfg_data <= h;
        @(negedge clk);
        cfg_idx  <= tbhd_pkg::CFG_SHIFT;
        cfg_data <= tbhd_pkg::CFG_W'(s);
        @(negedge clk);
        cfg_idx  <= tbhd_pkg::CFG_LIMIT;
        cfg_data <= l;
        @(negedge clk);
        cfg_we   <= 1'b0;
        tracker.hyst  = h;
        tracker.shift = s;
        tracker.limit = l;
        @(negedge clk);
    endtask

    initial begin
        int                         hyst_tab  [PHASES];
        int                         shift_tab [PHASES];
        int                         limit_tab [PHASES];
        int                         src_tab   [4];
        int                         snk_tab   [4];
        int                         h;
        int                         s;
        int                         l;
        int                         pick;
        int                         span;
        int                         val_i;
        logic [tbhd_pkg::ACT_W-1:0] act;
        logic [tbhd_pkg::CH_W-1:0]  ch;
        logic [tbhd_pkg::VAL_W-1:0] value;

        hyst_tab  = '{8, 0, 32767, -1, 16, 8, -1, 4};
        shift_tab = '{4, 0, 15, -1, 2, 4, -1, 1};
        limit_tab = '{32767, 32767, 1, -1, 0, 2000, -1, 32767};
        src_tab   = '{0, 60, 0, 8};
        snk_tab   = '{0, 0, 60, 8};

        tracker = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // clamp, touch set and release, saturation, baseline floor
        push_item(tbhd_pkg::ACT_SCAN, 3'd0, 16'h0000);
        push_item(tbhd_pkg::ACT_SCAN, 3'd0, 16'hFFFF);
        push_item(tbhd_pkg::ACT_SCAN, 3'd0, 16'hFFFF);
        push_item(tbhd_pkg::ACT_SCAN, 3'd0, 16'h0000);
        push_item(tbhd_pkg::ACT_SET_THR, 3'd1, 16'hFFFF);
        push_item(tbhd_pkg::ACT_SCAN, 3'd1, 16'h7FFF);
        push_item(tbhd_pkg::ACT_SET_THR, 3'd2, 16'h0000);
        push_item(tbhd_pkg::ACT_SCAN, 3'd2, 16'h0001);
        push_item(tbhd_pkg::ACT_SCAN, 3'd2, 16'h0000);
        push_item(tbhd_pkg::ACT_CAL, 3'd3, 16'd1000);
        push_item(tbhd_pkg::ACT_SCAN, 3'd3, 16'd1041);
        push_item(tbhd_pkg::ACT_SCAN, 3'd3, 16'd999);
        push_item(tbhd_pkg::ACT_SCAN, 3'd3, 16'd1030);
        push_item(tbhd_pkg::ACT_SCAN, 3'd3, 16'd900);
        push_item(ACT_NONE, 3'd4, 16'hAAAA);
        push_item(tbhd_pkg::ACT_CAL, 3'd5, 16'hFFFF);
        push_item(tbhd_pkg::ACT_SCAN, 3'd5, 16'h0000);
        push_item(tbhd_pkg::ACT_SET_THR, 3'd7, 16'h0000);
        push_item(tbhd_pkg::ACT_CAL, 3'd7, 16'h0001);
        push_item(tbhd_pkg::ACT_SCAN, 3'd7, 16'd10);
        push_item(tbhd_pkg::ACT_SCAN, 3'd7, 16'h0000);
        push_item(tbhd_pkg::ACT_SCAN, 3'd7, 16'h0000);
        push_item(tbhd_pkg::ACT_SET_THR, 3'd6, 16'h7FFE);
        push_item(tbhd_pkg::ACT_SET_THR, 3'd6, 16'h5555);
        push_item(ACT_NONE, 3'd6, 16'h0000);

        for (int p = 0; p < PHASES; p++) begin
            h = (hyst_tab[p]  < 0) ? $urandom_range(0, 64)    : hyst_tab[p];
            s = (shift_tab[p] < 0) ? $urandom_range(0, 15)    : shift_tab[p];
            l = (limit_tab[p] < 0) ? $urandom_range(1, 32767) : limit_tab[p];
            apply_config(tbhd_pkg::HYST_W'(h), tbhd_pkg::SHIFT_W'(s),
                         tbhd_pkg::BASE_W'(l));
            src_idle_pct  = src_tab[p % 4];
            snk_stall_pct = snk_tab[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                ch   = tbhd_pkg::CH_W'($urandom_range(0, N_CH - 1));
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    act = tbhd_pkg::ACT_SCAN;
                    if ($urandom_range(0, 99) < 75) begin
                        // near the baseline, around the touch and release levels
                        span  = int'(tracker.thr[ch]) * 2 + 16;
                        if (span > 4000) span = 4000;
                        val_i = int'(tracker.base[ch]) + int'($urandom_range(0, 2 * span))
                                - span;
                        if (val_i < 0) val_i = 0;
                        if (val_i > 65535) val_i = 65535;
                        value = val_i[tbhd_pkg::VAL_W-1:0];
                    end else begin
                        value = tbhd_pkg::VAL_W'($urandom_range(0, 65535));
                    end
                end else if (pick < 80) begin
                    act   = tbhd_pkg::ACT_CAL;
                    value = ($urandom_range(0, 99) < 70)
                          ? tbhd_pkg::VAL_W'($urandom_range(0, 4000))
                          : tbhd_pkg::VAL_W'($urandom_range(0, 65535));
                end else if (pick < 94) begin
                    act   = tbhd_pkg::ACT_SET_THR;
                    value = ($urandom_range(0, 99) < 80)
                          ? tbhd_pkg::VAL_W'($urandom_range(0, 200))
                          : tbhd_pkg::VAL_W'($urandom_range(0, 65535));
                end else begin
                    act   = ACT_NONE;
                    value = tbhd_pkg::VAL_W'($urandom_range(0, 65535));
                end
                push_item(act, ch, value);
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0 && tracker.due_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tbhd_pkg.sv
rtl/touch_baseline_hysteresis_detector.sv
verif/touch_baseline_hysteresis_detector_tb.sv
